@@ src/paged_block_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// paged block allocator assertion macros
// property forms used by the allocator datapath
// ----------------------------------------------------------------------------
`ifndef PAGED_BLOCK_ALLOCATOR_ASSERT_SVH
`define PAGED_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define PBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/pba_pkg.sv @@
// ----------------------------------------------------------------------------
// pba_pkg
// constants, codes and control structs of the paged block allocator
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int BLOCK_COUNT = 1024;
  localparam int BLK_W       = 10;
  localparam int CNT_W       = 11;
  localparam int MAX_SEQS    = 64;
  localparam int SLOT_W      = 6;
  localparam int TABLE_DEPTH = 32;
  localparam int POS_W       = 5;
  localparam int LEN_W       = 6;
  localparam int TOK_W       = 12;
  localparam int TPB_W       = 7;
  localparam int NEED_W      = 13;

  // request kinds
  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_FREE   = 2'd2;
  localparam logic [1:0] KIND_RESET  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFREE  = 2'd1;
  localparam logic [1:0] ST_DEPTH   = 2'd2;
  localparam logic [1:0] ST_NOTPRES = 2'd3;

  // side effect of a single result
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_EMPTY   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  typedef struct packed {
    logic       load;
    logic       clear_all;
    logic       start_alloc;
    logic       start_append;
    logic       start_free;
    logic       fifo_rd;
    logic       pop_emit;
    logic       tbl_rd;
    logic       push;
    logic       emit;
    logic [1:0] status;
    logic [1:0] act;
  } cmd_t;

  typedef struct packed {
    logic       div_busy;
    logic       out_busy;
    logic [1:0] kind;
    logic       chk;
    logic       present;
    logic       need_over;
    logic       need_gt_free;
    logic       need_zero;
    logic       app_due;
    logic       len_full;
    logic       free_zero;
    logic       len_zero;
    logic       pop_last;
    logic       free_last;
  } sts_t;

endpackage

@@ src/paged_block_allocator.sv @@
// ----------------------------------------------------------------------------
// paged_block_allocator
// block allocator for a paged key/value cache with per-slot block tables
// ----------------------------------------------------------------------------
// usage
//   requests enter on in_valid/in_ready, one transfer per request; results
//   leave on out_valid/out_ready, one transfer per result, last marks the
//   final result of a request. tokens_per_block is written by cfg_we with
//   cfg_wdata only while the block is idle, a rule the block does not enforce.
// sequence
//   one request at a time. every request passes a capture state, the
//   restoring divider and a decision state; a request with a single result
//   then emits it. allocate and append read the free list and emit a result
//   per block (free list read and result), free reads each table entry and
//   pushes it to the list (table read and list push) before its result. the
//   one-port free list and block table memories make each walk step through
//   one block at a time.
// reset
//   rst resets pointers, presence and the free count; free list entries
//   not yet written read as their own index, so no clearing pass is needed.
// stall
//   a waiting result holds the sequencer; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module paged_block_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  kind,
  input  logic [pba_pkg::SLOT_W-1:0]  seq_slot,
  input  logic [pba_pkg::TOK_W-1:0]   token_count,
  input  logic                        check_only,
  input  logic                        cfg_we,
  input  logic [pba_pkg::TPB_W-1:0]   cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic                        block_valid,
  output logic [pba_pkg::BLK_W-1:0]   block_number,
  output logic [pba_pkg::POS_W-1:0]   table_position,
  output logic [pba_pkg::CNT_W-1:0]   free_count,
  output logic                        last
);
  import pba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  pba_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .kind           (kind),
    .seq_slot       (seq_slot),
    .token_count    (token_count),
    .check_only     (check_only),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .status         (status),
    .block_valid    (block_valid),
    .block_number   (block_number),
    .table_position (table_position),
    .free_count     (free_count),
    .last           (last)
  );

endmodule

@@ src/pba_div.sv @@
// ----------------------------------------------------------------------------
// pba_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pba_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pba_pkg::TOK_W-1:0]  dividend,
  input  logic [pba_pkg::TPB_W-1:0]  divisor,
  output logic                       busy,
  output logic [pba_pkg::TOK_W-1:0]  quo,
  output logic [pba_pkg::TPB_W-1:0]  rem
);
  import pba_pkg::*;

  logic [3:0]       cnt;
  logic [TOK_W-1:0] q;
  logic [TPB_W:0]   r;
  logic [TPB_W-1:0] d;
  logic [TPB_W:0]   shifted;
  logic             fits;

  // trial subtract
  always_comb begin
    shifted = {r[TPB_W-1:0], q[TOK_W-1]};
    fits    = shifted >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      q    <= dividend;
      r    <= '0;
      d    <= divisor;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      r    <= fits ? (shifted - {1'b0, d}) : shifted;
      q    <= {q[TOK_W-2:0], fits};
      cnt  <= cnt + 4'd1;
      if (cnt == 4'(TOK_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quo = q;
  assign rem = r[TPB_W-1:0];

endmodule

@@ src/pba_ctrl.sv @@
// ----------------------------------------------------------------------------
// pba_ctrl
// sequencer that steps the allocator datapath through each request
// ----------------------------------------------------------------------------
module pba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pba_pkg::sts_t sts,
  output pba_pkg::cmd_t cmd
);
  import pba_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV    = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_EMIT   = 4'd3;
  localparam logic [3:0] S_AREAD  = 4'd4;
  localparam logic [3:0] S_AEMIT  = 4'd5;
  localparam logic [3:0] S_FREAD  = 4'd6;
  localparam logic [3:0] S_FPUSH  = 4'd7;

  logic [3:0] state, state_next;
  logic [1:0] st_status, st_status_next;
  logic [1:0] st_act, st_act_next;

  // next state and commands
  always_comb begin
    state_next     = state;
    st_status_next = st_status;
    st_act_next    = st_act;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next     = S_EMIT;
        st_status_next = ST_OK;
        st_act_next    = ACT_NONE;
        if (sts.kind == KIND_RESET) begin
          cmd.clear_all = 1'b1;
        end else if (sts.kind == KIND_ALLOC) begin
          if (sts.need_over) st_status_next = ST_DEPTH;
          else if (sts.need_gt_free) st_status_next = ST_NOFREE;
          else if (sts.chk) st_status_next = ST_OK;
          else if (sts.need_zero) st_act_next = ACT_EMPTY;
          else begin
            cmd.start_alloc = 1'b1;
            state_next      = S_AREAD;
          end
        end else if (!sts.present) begin
          st_status_next = ST_NOTPRES;
        end else if (sts.kind == KIND_APPEND) begin
          if (!sts.app_due) st_status_next = ST_OK;
          else if (sts.len_full) st_status_next = ST_DEPTH;
          else if (sts.free_zero) st_status_next = ST_NOFREE;
          else if (!sts.chk) begin
            cmd.start_append = 1'b1;
            state_next       = S_AREAD;
          end
        end else begin
          st_act_next = ACT_RELEASE;
          if (!sts.len_zero) begin
            cmd.start_free = 1'b1;
            state_next     = S_FREAD;
          end
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          cmd.status = st_status;
          cmd.act    = st_act;
          state_next = S_IDLE;
        end
      end
      S_AREAD: begin
        cmd.fifo_rd = 1'b1;
        state_next  = S_AEMIT;
      end
      S_AEMIT: begin
        if (!sts.out_busy) begin
          cmd.pop_emit = 1'b1;
          state_next   = sts.pop_last ? S_IDLE : S_AREAD;
        end
      end
      S_FREAD: begin
        cmd.tbl_rd = 1'b1;
        state_next = S_FPUSH;
      end
      S_FPUSH: begin
        cmd.push   = 1'b1;
        state_next = sts.free_last ? S_EMIT : S_FREAD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    st_status <= st_status_next;
    st_act    <= st_act_next;
  end

endmodule

@@ src/pba_dp.sv @@
// ----------------------------------------------------------------------------
// pba_dp
// allocator datapath: free list, block tables, lengths and result register
// ----------------------------------------------------------------------------
module pba_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  pba_pkg::cmd_t               cmd,
  output pba_pkg::sts_t               sts,
  input  logic [1:0]                  kind,
  input  logic [pba_pkg::SLOT_W-1:0]  seq_slot,
  input  logic [pba_pkg::TOK_W-1:0]   token_count,
  input  logic                        check_only,
  input  logic                        cfg_we,
  input  logic [pba_pkg::TPB_W-1:0]   cfg_wdata,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [1:0]                  status,
  output logic                        block_valid,
  output logic [pba_pkg::BLK_W-1:0]   block_number,
  output logic [pba_pkg::POS_W-1:0]   table_position,
  output logic [pba_pkg::CNT_W-1:0]   free_count,
  output logic                        last
);
  import pba_pkg::*;
  `include "paged_block_allocator_assert.svh"

  logic [TPB_W-1:0]  tpb;
  logic [1:0]        kind_r;
  logic [SLOT_W-1:0] slot_r;
  logic              chk_r;
  logic              is_app;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  pos;
  logic [MAX_SEQS-1:0] present;
  logic [BLK_W-1:0]  head, tail, head_q;
  logic              wrapped, fifo_sel;
  logic [CNT_W-1:0]  ftotal;
  logic [BLK_W-1:0]  fifo_q, tbl_q, blk;

  logic [BLK_W-1:0]  fifo_mem [BLOCK_COUNT];
  logic [BLK_W-1:0]  tbl_mem  [MAX_SEQS*TABLE_DEPTH];
  logic [LEN_W-1:0]  len_mem  [MAX_SEQS];

  logic [TOK_W-1:0]  quo;
  logic [TPB_W-1:0]  rem;
  logic              div_busy;
  logic [TPB_W-1:0]  divisor;
  logic [NEED_W-1:0] need;
  logic [LEN_W-1:0]  pos_inc;
  logic [SLOT_W+POS_W-1:0] tbl_addr;
  logic              pop_last;

  // divider, a zero divisor acts as one
  assign divisor = (tpb == '0) ? TPB_W'(1) : tpb;

  pba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .dividend (token_count),
    .divisor  (divisor),
    .busy     (div_busy),
    .quo      (quo),
    .rem      (rem)
  );

  // derived values and status
  always_comb begin
    need     = {1'b0, quo} + NEED_W'(rem != '0);
    pos_inc  = pos + LEN_W'(1);
    tbl_addr = {slot_r, pos[POS_W-1:0]};
    blk      = fifo_sel ? fifo_q : head_q;
    pop_last = is_app || (pos_inc == need[LEN_W-1:0]);

    sts.div_busy     = div_busy;
    sts.out_busy     = out_valid;
    sts.kind         = kind_r;
    sts.chk          = chk_r;
    sts.present      = present[slot_r];
    sts.need_over    = need > NEED_W'(TABLE_DEPTH);
    sts.need_gt_free = need > NEED_W'(ftotal);
    sts.need_zero    = need == '0;
    sts.app_due      = rem == TPB_W'(1);
    sts.len_full     = len_r >= LEN_W'(TABLE_DEPTH);
    sts.free_zero    = ftotal == '0;
    sts.len_zero     = len_r == '0;
    sts.pop_last     = pop_last;
    sts.free_last    = pos_inc == len_r;
  end

  // request capture and walk position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      slot_r <= seq_slot;
      chk_r  <= check_only;
    end
    if (cmd.start_alloc) begin
      pos    <= '0;
      is_app <= 1'b0;
    end else if (cmd.start_append) begin
      pos    <= len_r;
      is_app <= 1'b1;
    end else if (cmd.start_free) begin
      pos    <= '0;
    end else if (cmd.pop_emit || cmd.push) begin
      pos    <= pos_inc;
    end
  end

  // length memory
  always_ff @(posedge clk) begin
    if (cmd.load) len_r <= len_mem[seq_slot];
    if (cmd.pop_emit && pop_last) begin
      len_mem[slot_r] <= pos_inc;
    end else if (cmd.emit && cmd.act == ACT_EMPTY) begin
      len_mem[slot_r] <= '0;
    end
  end

  // block table memory
  always_ff @(posedge clk) begin
    if (cmd.tbl_rd) tbl_q <= tbl_mem[tbl_addr];
    if (cmd.pop_emit) tbl_mem[tbl_addr] <= blk;
  end

  // free list memory, unwritten entries read as their own index
  always_ff @(posedge clk) begin
    if (cmd.fifo_rd) begin
      fifo_q   <= fifo_mem[head];
      fifo_sel <= wrapped || (head < tail);
      head_q   <= head;
    end
    if (cmd.push && ftotal < CNT_W'(BLOCK_COUNT)) begin
      fifo_mem[tail] <= tbl_q;
    end
  end

  // control state: config, pointers, presence, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tpb       <= TPB_W'(16);
      head      <= '0;
      tail      <= '0;
      wrapped   <= 1'b0;
      ftotal    <= CNT_W'(BLOCK_COUNT);
      present   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) tpb <= cfg_wdata;
      if (cmd.clear_all) begin
        head    <= '0;
        tail    <= '0;
        wrapped <= 1'b0;
        ftotal  <= CNT_W'(BLOCK_COUNT);
        present <= '0;
      end
      if (cmd.pop_emit) begin
        head   <= (head == BLK_W'(BLOCK_COUNT - 1)) ? '0 : head + BLK_W'(1);
        ftotal <= ftotal - CNT_W'(1);
        if (pop_last) present[slot_r] <= 1'b1;
      end
      if (cmd.push && ftotal < CNT_W'(BLOCK_COUNT)) begin
        tail   <= (tail == BLK_W'(BLOCK_COUNT - 1)) ? '0 : tail + BLK_W'(1);
        ftotal <= ftotal + CNT_W'(1);
        if (tail == BLK_W'(BLOCK_COUNT - 1)) wrapped <= 1'b1;
      end
      if (cmd.emit && cmd.act == ACT_EMPTY) present[slot_r] <= 1'b1;
      if (cmd.emit && cmd.act == ACT_RELEASE) present[slot_r] <= 1'b0;
      if (cmd.emit || cmd.pop_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status         <= cmd.status;
      block_valid    <= 1'b0;
      block_number   <= '0;
      table_position <= '0;
      free_count     <= ftotal;
      last           <= 1'b1;
    end else if (cmd.pop_emit) begin
      status         <= ST_OK;
      block_valid    <= 1'b1;
      block_number   <= blk;
      table_position <= pos[POS_W-1:0];
      free_count     <= ftotal - CNT_W'(1);
      last           <= pop_last;
    end
  end

  `PBA_ASSERT_NOW(a_pop_nonempty, cmd.pop_emit, ftotal != '0, "pop from empty free list")
  `PBA_ASSERT_NOW(a_emit_slot_free, cmd.emit || cmd.pop_emit, !out_valid, "result overwritten")
  `PBA_ASSERT_NEXT(a_clear_full, cmd.clear_all, ftotal == CNT_W'(BLOCK_COUNT), "clear left list short")

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// paged block allocator testbench
// drives allocate, append, free and reset-all requests through the valid/ready
// request channel with random gaps and output stalls; every result is compared
// against an in-bench model of free list, counts and block tables
// ----------------------------------------------------------------------------
module testbench;
  import pba_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]       status;
    logic             block_valid;
    logic [BLK_W-1:0] block_number;
    logic [POS_W-1:0] table_position;
    logic [CNT_W-1:0] free_count;
    logic             last;
  } alloc_result_t;

  typedef struct {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [TOK_W-1:0]  tokens;
    logic              chk;
    logic              has_exp;
    logic [1:0]        exp_status;
  } request_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = KIND_ALLOC;
  logic [SLOT_W-1:0] seq_slot = '0;
  logic [TOK_W-1:0] token_count = '0;
  logic check_only = 1'b0;
  logic cfg_we = 1'b0;
  logic [TPB_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic block_valid;
  logic [BLK_W-1:0] block_number;
  logic [POS_W-1:0] table_position;
  logic [CNT_W-1:0] free_count;
  logic last;

  // model state
  int unsigned tpb_reg;
  int unsigned fl_mem [BLOCK_COUNT];
  int unsigned fl_head, fl_tail, fl_total;
  int unsigned blk_refs [BLOCK_COUNT];
  int unsigned slot_table [MAX_SEQS][TABLE_DEPTH];
  int unsigned slot_len [MAX_SEQS];
  bit          slot_live [MAX_SEQS];

  alloc_result_t expected_results [$];
  logic [1:0] directed_status [$];
  int errors = 0;
  int idle_cycles = 0;
  bit stall_burst = 1'b0;

  paged_block_allocator u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .seq_slot(seq_slot), .token_count(token_count), .check_only(check_only),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .block_valid(block_valid),
    .block_number(block_number), .table_position(table_position),
    .free_count(free_count), .last(last)
  );

  always #6 clk = ~clk;

  // model reset of allocator state, register untouched
  function automatic void clear_model();
    for (int i = 0; i < BLOCK_COUNT; i++) begin
      fl_mem[i] = i;
      blk_refs[i] = 0;
    end
    fl_head = 0;
    fl_tail = 0;
    fl_total = BLOCK_COUNT;
    for (int s = 0; s < MAX_SEQS; s++) begin
      slot_len[s] = 0;
      slot_live[s] = 1'b0;
    end
  endfunction

  function automatic void push_result(logic [1:0] st, logic bv, int unsigned blk,
                                      int unsigned pos, logic lst);
    alloc_result_t r;
    r.status = st;
    r.block_valid = bv;
    r.block_number = blk[BLK_W-1:0];
    r.table_position = pos[POS_W-1:0];
    r.free_count = fl_total[CNT_W-1:0];
    r.last = lst;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic int unsigned take_block();
    int unsigned b;
    b = fl_mem[fl_head];
    fl_head = (fl_head + 1 >= BLOCK_COUNT) ? 0 : fl_head + 1;
    fl_total--;
    return b;
  endfunction

  // predict results of one accepted request
  function automatic void predict_request(logic [1:0] k, int unsigned s, int unsigned tok,
                                          logic chk);
    int unsigned tpb, need, b, len;
    tpb = (tpb_reg == 0) ? 1 : tpb_reg;
    if (k == KIND_RESET) begin
      clear_model();
      push_result(ST_OK, 1'b0, 0, 0, 1'b1);
      return;
    end
    if (k == KIND_ALLOC) begin
      need = (tok + tpb - 1) / tpb;
      if (need > TABLE_DEPTH) push_result(ST_DEPTH, 1'b0, 0, 0, 1'b1);
      else if (need > fl_total) push_result(ST_NOFREE, 1'b0, 0, 0, 1'b1);
      else if (chk || need == 0) begin
        if (!chk) begin
          slot_live[s] = 1'b1;
          slot_len[s] = 0;
        end
        push_result(ST_OK, 1'b0, 0, 0, 1'b1);
      end else begin
        for (int i = 0; i < need; i++) begin
          b = take_block();
          blk_refs[b] = 1;
          slot_table[s][i] = b;
          push_result(ST_OK, 1'b1, b, i, i + 1 == need);
        end
        slot_live[s] = 1'b1;
        slot_len[s] = need;
      end
      return;
    end
    if (!slot_live[s]) begin
      push_result(ST_NOTPRES, 1'b0, 0, 0, 1'b1);
      return;
    end
    len = slot_len[s];
    if (k == KIND_APPEND) begin
      if (tok % tpb != 1) push_result(ST_OK, 1'b0, 0, 0, 1'b1);
      else if (len >= TABLE_DEPTH) push_result(ST_DEPTH, 1'b0, 0, 0, 1'b1);
      else if (fl_total == 0) push_result(ST_NOFREE, 1'b0, 0, 0, 1'b1);
      else if (chk) push_result(ST_OK, 1'b0, 0, 0, 1'b1);
      else begin
        b = take_block();
        blk_refs[b] = 1;
        slot_table[s][len] = b;
        slot_len[s] = len + 1;
        push_result(ST_OK, 1'b1, b, len, 1'b1);
      end
      return;
    end
    // free: walk the table and return blocks to the tail
    for (int i = 0; i < len; i++) begin
      b = slot_table[s][i];
      if (blk_refs[b] > 1) blk_refs[b]--;
      else begin
        blk_refs[b] = 0;
        if (fl_total < BLOCK_COUNT) begin
          fl_mem[fl_tail] = b;
          fl_tail = (fl_tail + 1 >= BLOCK_COUNT) ? 0 : fl_tail + 1;
          fl_total++;
        end
      end
    end
    slot_live[s] = 1'b0;
    slot_len[s] = 0;
    push_result(ST_OK, 1'b0, 0, 0, 1'b1);
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // send one request and hold it until the transfer
  task automatic send_request(logic [1:0] k, logic [SLOT_W-1:0] s, logic [TOK_W-1:0] tok,
                              logic chk, bit no_gap);
    int gap;
    gap = no_gap ? 0 : gap_len();
    // valid of the previous request drops on the falling edge before this one
    repeat (gap + 1) @(negedge clk);
    kind <= k;
    seq_slot <= s;
    token_count <= tok;
    check_only <= chk;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(k, s, tok, chk);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_tpb(int unsigned v);
    wait_drained();
    cfg_wdata <= v[TPB_W-1:0];
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    tpb_reg = v;
  endtask

  // result side: random stalls, compare at the rising edge
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else begin
      if ($urandom_range(0, 99) == 0) stall_burst = ~stall_burst;
      out_ready <= stall_burst ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    alloc_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{status, block_valid, block_number, table_position, free_count, last};
      if (expected_results.size() == 0) begin
        $display("%0t: result expected none actual %p", $time, got);
        errors++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (directed_status.size() != 0 && want.last) begin
          if (got.status !== directed_status[0])
            $display("%0t: directed status expected %0d actual %0d", $time,
                     directed_status[0], got.status);
          if (got.status !== directed_status[0]) errors++;
          directed_status.delete(0);
        end
        if (got.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got.block_valid !== want.block_valid)
          $display("%0t: block_valid expected %0d actual %0d", $time, want.block_valid,
                   got.block_valid);
        if (got.block_number !== want.block_number)
          $display("%0t: block_number expected %0d actual %0d", $time, want.block_number,
                   got.block_number);
        if (got.table_position !== want.table_position)
          $display("%0t: table_position expected %0d actual %0d", $time,
                   want.table_position, got.table_position);
        if (got.free_count !== want.free_count)
          $display("%0t: free_count expected %0d actual %0d", $time, want.free_count,
                   got.free_count);
        if (got.last !== want.last)
          $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        if (got !== want) errors++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // directed table: expected status typed in where obvious
  request_row_t directed_rows [] = '{
    '{KIND_APPEND, 6'd5,  12'd1,    1'b0, 1'b1, ST_NOTPRES},
    '{KIND_FREE,   6'd5,  12'd0,    1'b0, 1'b1, ST_NOTPRES},
    '{KIND_ALLOC,  6'd0,  12'd0,    1'b0, 1'b1, ST_OK},
    '{KIND_ALLOC,  6'd1,  12'd4095, 1'b0, 1'b1, ST_DEPTH},
    '{KIND_ALLOC,  6'd1,  12'd513,  1'b1, 1'b1, ST_DEPTH},
    '{KIND_ALLOC,  6'd1,  12'd512,  1'b1, 1'b1, ST_OK},
    '{KIND_ALLOC,  6'd63, 12'd512,  1'b0, 1'b0, ST_OK},
    '{KIND_APPEND, 6'd63, 12'd513,  1'b0, 1'b1, ST_DEPTH},
    '{KIND_APPEND, 6'd0,  12'd17,   1'b1, 1'b1, ST_OK},
    '{KIND_APPEND, 6'd0,  12'd17,   1'b0, 1'b0, ST_OK},
    '{KIND_APPEND, 6'd0,  12'd18,   1'b0, 1'b1, ST_OK},
    '{KIND_ALLOC,  6'd2,  12'd33,   1'b0, 1'b0, ST_OK},
    '{KIND_ALLOC,  6'd2,  12'd16,   1'b0, 1'b0, ST_OK},
    '{KIND_FREE,   6'd2,  12'd0,    1'b1, 1'b1, ST_OK},
    '{KIND_FREE,   6'd63, 12'd0,    1'b0, 1'b1, ST_OK},
    '{KIND_RESET,  6'd42, 12'd2048, 1'b1, 1'b1, ST_OK},
    '{KIND_FREE,   6'd0,  12'd0,    1'b0, 1'b1, ST_NOTPRES}
  };

  int unsigned tpb_settings [] = '{1, 127, 0, 64, 5, 16};
  int sent;
  logic [1:0] rk;
  logic [SLOT_W-1:0] rs;
  logic [TOK_W-1:0] rt;
  int unsigned tpb_now;

  initial begin
    tpb_reg = 16;
    clear_model();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_tpb(16);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].has_exp) begin
        while (expected_results.size() != 0) @(negedge clk);
        directed_status.insert(directed_status.size(), directed_rows[i].exp_status);
      end
      send_request(directed_rows[i].kind, directed_rows[i].slot, directed_rows[i].tokens,
                   directed_rows[i].chk, 1'b0);
      if (directed_rows[i].has_exp)
        while (expected_results.size() != 0) @(negedge clk);
    end

    // exhaust the free list with full allocations, then probe the out-of-blocks cases
    write_tpb(1);
    for (int s = 0; s < 32; s++) send_request(KIND_ALLOC, s[SLOT_W-1:0], 12'd32, 1'b0, 1'b1);
    send_request(KIND_ALLOC, 6'd40, 12'd1, 1'b0, 1'b0);
    send_request(KIND_APPEND, 6'd3, 12'd1, 1'b0, 1'b0);
    send_request(KIND_ALLOC, 6'd0, 12'd32, 1'b0, 1'b0);
    send_request(KIND_FREE, 6'd0, 12'd0, 1'b0, 1'b0);
    send_request(KIND_FREE, 6'd1, 12'd0, 1'b0, 1'b0);
    send_request(KIND_RESET, 6'd0, 12'd0, 1'b0, 1'b0);

    // random phases under several divisor settings
    sent = 0;
    foreach (tpb_settings[p]) begin
      write_tpb(tpb_settings[p]);
      tpb_now = (tpb_settings[p] == 0) ? 1 : tpb_settings[p];
      for (int n = 0; n < 60; n++) begin
        rs = ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom_range(0, 63)) :
                                           SLOT_W'($urandom_range(0, 7));
        case ($urandom_range(0, 19))
          0: rt = TOK_W'($urandom_range(0, 4095));
          1, 2, 3, 4, 5, 6: rt = TOK_W'($urandom_range(0, tpb_now *
                                 (($urandom_range(0, 7) == 0) ? 33 : 6)));
          default: rt = TOK_W'(tpb_now * $urandom_range(0, 34) + 1);
        endcase
        case ($urandom_range(0, 39))
          0: rk = KIND_RESET;
          1, 2, 3, 4, 5, 6, 7, 8: rk = KIND_FREE;
          9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19: rk = KIND_ALLOC;
          default: rk = KIND_APPEND;
        endcase
        send_request(rk, rs, rt, $urandom_range(0, 5) == 0, 1'b0);
        sent++;
        if (sent % 150 == 75) wait_drained();
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/pba_pkg.sv
src/pba_div.sv
src/pba_ctrl.sv
src/pba_dp.sv
src/paged_block_allocator.sv
tb/testbench.sv
